/* design/mrlt_pkg.sv */
// Package for the multi-resource lock table: field widths, request kinds,
// parameter defaults and the request/response structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mrlt_pkg;

    localparam int FUNC_W = 2;   // request kind field
    localparam int ID_W   = 8;   // requester id field
    localparam int MASK_W = 16;  // resource mask and busy mask fields

    localparam int NUM_RESOURCES_DEF = 16;
    localparam int ID_BITS_DEF       = 8;

    // Request kinds; the unused code acts as a check.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_CHECK   = 2'd2
    } t_func;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   requester_id;
        logic [MASK_W-1:0] resource_mask;
    } t_req;

    typedef struct packed {
        logic              ok;
        logic [MASK_W-1:0] busy_mask;
    } t_rsp;

endpackage

`default_nettype wire

/* design/mrlt_if.sv */
// Handshake interfaces for the request and response channels.
// Depends on mrlt_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface mrlt_req_if import mrlt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FUNC_W-1:0] func;
    logic [ID_W-1:0]   requester_id;
    logic [MASK_W-1:0] resource_mask;

    modport source (output valid, output func, output requester_id,
                    output resource_mask, input ready);
    modport sink   (input valid, input func, input requester_id,
                    input resource_mask, output ready);
endinterface

interface mrlt_rsp_if import mrlt_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              ok;
    logic [MASK_W-1:0] busy_mask;

    modport source (output valid, output ok, output busy_mask, input ready);
    modport sink   (input valid, input ok, input busy_mask, output ready);
endinterface

`default_nettype wire

/* design/multi_resource_lock_table.sv */
// Multi-resource lock table, top level: input register, lock core, result register.
// An accepted request transaction is held in the input register, and its result is then
// held in the result register until the response sink takes it.
// Throughput: one request per cycle while the sink takes results; the owner compares over
// all resources run in parallel in the lock core, between the input and result registers.
// Reset (synchronous, active low): all busy flags and owners cleared, both
// register stages emptied; requests are taken from the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module multi_resource_lock_table import mrlt_pkg::*; #(
    parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
    parameter int ID_BITS       = ID_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mrlt_req_if.sink    i_req,
    mrlt_rsp_if.source  o_rsp
);

    // Input stage: holds one request transaction until the core takes it.
    logic r_in_valid;
    t_req r_in_req;

    // Result stage: holds one response transaction until the sink takes it.
    logic r_out_valid;
    t_rsp r_out_rsp;

    logic advance;   // result stage free or draining this cycle
    logic fire;      // core processes the held request and updates state
    t_rsp core_rsp;

    assign advance     = ~r_out_valid | o_rsp.ready;
    assign fire        = r_in_valid & advance;
    // Input stage refills in the same cycle it hands its request on.
    assign i_req.ready = ~r_in_valid | advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_req.func          <= i_req.func;
            r_in_req.requester_id  <= i_req.requester_id;
            r_in_req.resource_mask <= i_req.resource_mask;
        end
    end

    // State is read and written only here, so each request sees the
    // table exactly as the previous one left it.
    mrlt_lock_core #(
        .NUM_RESOURCES (NUM_RESOURCES),
        .ID_BITS       (ID_BITS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (r_in_req),
        .o_rsp   (core_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_rsp <= core_rsp;
        end
    end

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.ok        = r_out_rsp.ok;
    assign o_rsp.busy_mask = r_out_rsp.busy_mask;

endmodule

`default_nettype wire

/* design/mrlt_lock_core.sv */
// Lock table state (busy flags, owner ids) and the single-pass update logic.
// Depends on mrlt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mrlt_lock_core import mrlt_pkg::*; #(
    parameter int NUM_RESOURCES = NUM_RESOURCES_DEF,
    parameter int ID_BITS       = ID_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_fire,
    input  wire t_req i_req,
    output t_rsp      o_rsp
);

    logic [NUM_RESOURCES-1:0] r_busy;
    logic [NUM_RESOURCES-1:0] n_busy;
    logic [ID_BITS-1:0]       r_owner [NUM_RESOURCES];
    logic [ID_BITS-1:0]       n_owner [NUM_RESOURCES];

    logic [ID_BITS-1:0]       who;
    logic [NUM_RESOURCES-1:0] named;
    logic [NUM_RESOURCES-1:0] match;
    logic [NUM_RESOURCES-1:0] clash;
    logic                     conflict;
    logic                     ok;
    logic [MASK_W-1:0]        busy_word;

    // Id compared on its low ID_BITS bits (zero-extended when wider).
    assign who = ID_BITS'(i_req.requester_id);

    for (genvar i = 0; i < NUM_RESOURCES; i++) begin : g_res
        if (i < MASK_W) begin : g_named
            assign named[i] = i_req.resource_mask[i];
        end else begin : g_unnamed
            assign named[i] = 1'b0;
        end
        assign match[i] = (r_owner[i] == who);
        assign clash[i] = named[i] & r_busy[i] & ~match[i];
    end

    // Freeing own resources first never removes a foreign owner's busy flag,
    // so the allocate conflict is the same as the check conflict.
    assign conflict = |clash;

    always_comb begin
        n_busy  = r_busy;
        n_owner = r_owner;
        ok      = 1'b1;
        case (t_func'(i_req.func))
            FUNC_ALLOC: begin
                n_busy = r_busy & ~match;
                if (conflict) begin
                    ok = 1'b0;
                end else begin
                    n_busy = n_busy | named;
                    for (int k = 0; k < NUM_RESOURCES; k++) begin
                        if (named[k]) begin
                            n_owner[k] = who;
                        end
                    end
                end
            end
            FUNC_RELEASE: begin
                n_busy = r_busy & ~named;
            end
            default: begin
                ok = ~conflict;
            end
        endcase
    end

    for (genvar j = 0; j < MASK_W; j++) begin : g_word
        if (j < NUM_RESOURCES) begin : g_live
            assign busy_word[j] = n_busy[j];
        end else begin : g_zero
            assign busy_word[j] = 1'b0;
        end
    end

    assign o_rsp.ok        = ok;
    assign o_rsp.busy_mask = busy_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
            for (int k = 0; k < NUM_RESOURCES; k++) begin
                r_owner[k] <= '0;
            end
        end else if (i_fire) begin
            r_busy  <= n_busy;
            r_owner <= n_owner;
        end
    end

endmodule

`default_nettype wire

/* bench/lock_table_checker.sv */
// Checker for the multi-resource lock table: watches both channels, predicts each result.
// Compares results field by field. Depends on mrlt_pkg and the channel interfaces in mrlt_if.
`timescale 1ns / 1ps

module lock_table_checker import mrlt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mrlt_req_if       req_mon,
    mrlt_rsp_if       rsp_mon,
    output int        o_error_count,
    output int        o_pending
);

    localparam int              NUM_RES    = NUM_RESOURCES_DEF;
    localparam int              OWNER_BITS = ID_BITS_DEF;
    localparam logic [ID_W-1:0] OWNER_KEEP = ID_W'((1 << OWNER_BITS) - 1);

    logic            lock_busy  [NUM_RES];
    logic [ID_W-1:0] lock_owner [NUM_RES];
    t_rsp            expected_rsp_q [$];

    task automatic report_mismatch(input string what, input int unsigned want_v,
                                   input int unsigned got_v);
        $display("%0t ns: MISMATCH %s: expected 'h%0h, got 'h%0h", $time, what, want_v, got_v);
        o_error_count = o_error_count + 1;
    endtask

    function automatic bit named(input logic [MASK_W-1:0] mask, input int idx);
        return (idx < MASK_W) && mask[idx];
    endfunction

    // Any named resource still held by someone else.
    function automatic bit held_by_other(input logic [MASK_W-1:0] mask,
                                         input logic [ID_W-1:0] who);
        for (int i = 0; i < NUM_RES; i++)
            if (named(mask, i) && lock_busy[i] && lock_owner[i] != who)
                return 1'b1;
        return 1'b0;
    endfunction

    // Updates the lock table for one request and returns its result.
    function automatic t_rsp apply_lock_request(input t_req r);
        t_rsp            res;
        logic [ID_W-1:0] who;
        who    = r.requester_id & OWNER_KEEP;
        res.ok = 1'b1;
        case (r.func)
            FUNC_ALLOC: begin
                // freeing of own resources sticks even if the grab fails
                for (int i = 0; i < NUM_RES; i++)
                    if (lock_owner[i] == who)
                        lock_busy[i] = 1'b0;
                if (held_by_other(r.resource_mask, who)) begin
                    res.ok = 1'b0;
                end else begin
                    for (int i = 0; i < NUM_RES; i++)
                        if (named(r.resource_mask, i)) begin
                            lock_owner[i] = who;
                            lock_busy[i]  = 1'b1;
                        end
                end
            end
            FUNC_RELEASE: begin
                for (int i = 0; i < NUM_RES; i++)
                    if (named(r.resource_mask, i))
                        lock_busy[i] = 1'b0;
            end
            default: begin
                res.ok = !held_by_other(r.resource_mask, who);
            end
        endcase
        res.busy_mask = '0;
        for (int i = 0; i < NUM_RES && i < MASK_W; i++)
            res.busy_mask[i] = lock_busy[i];
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        t_req seen;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_RES; i++) begin
                lock_busy[i]  = 1'b0;
                lock_owner[i] = '0;
            end
            expected_rsp_q.delete();
            o_error_count = 0;
        end else begin
            // result of this edge belongs to an earlier request, so pop first
            if (rsp_mon.valid && rsp_mon.ready) begin
                if (expected_rsp_q.size() == 0) begin
                    report_mismatch("result with no request outstanding", 0,
                                    {rsp_mon.ok, rsp_mon.busy_mask});
                end else begin
                    want = expected_rsp_q.pop_front();
                    if (rsp_mon.ok !== want.ok)
                        report_mismatch("ok", want.ok, rsp_mon.ok);
                    if (rsp_mon.busy_mask !== want.busy_mask)
                        report_mismatch("busy_mask", want.busy_mask, rsp_mon.busy_mask);
                end
            end
            if (req_mon.valid && req_mon.ready) begin
                seen.func          = req_mon.func;
                seen.requester_id  = req_mon.requester_id;
                seen.resource_mask = req_mon.resource_mask;
                expected_rsp_q.push_back(apply_lock_request(seen));
            end
        end
        o_pending = expected_rsp_q.size();
    end

endmodule

/* bench/testbench.sv */
// Top of the lock table testbench: clock, reset, request stimulus, response back-pressure.
// Depends on mrlt_pkg, mrlt_if, the block itself and lock_table_checker.
`timescale 1ns / 1ps

module testbench;
    import mrlt_pkg::*;

    // Cycles with no transaction on either channel before the run is called hung.
    // Longest planned quiet stretch is the receiver hold-off below.
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int ITEMS_PER_PHASE = 120;

    logic i_clk;
    logic i_rst_n;

    mrlt_req_if req_ch ();
    mrlt_rsp_if rsp_ch ();

    int error_count;
    int pending;
    int quiet_cycles;

    // Idle knobs, percent per cycle. Written by the main process after a rising
    // edge, read by the response driver at the falling edge and by send_request as it starts.
    int tx_idle_pct;
    int rx_stall_pct;
    bit hold_request;

    multi_resource_lock_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    lock_table_checker lock_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .req_mon       (req_ch),
        .rsp_mon       (rsp_ch),
        .o_error_count (error_count),
        .o_pending     (pending)
    );

    // 20 ns period
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    // Response side: random stalls, or one long hold-off when asked. The hold-off
    // is counted here so the sender keeps offering and the block backs up.
    initial begin : rsp_driver
        int hold_left;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                rsp_ch.ready <= 1'b0;
                hold_left--;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // Hang detector: counts cycles without any transaction.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_req make_req(input logic [FUNC_W-1:0] f,
                                      input logic [ID_W-1:0] id,
                                      input logic [MASK_W-1:0] mask);
        t_req r;
        r.func          = f;
        r.requester_id  = id;
        r.resource_mask = mask;
        return r;
    endfunction

    // Offer one request at the falling edge, hold it until the transaction.
    // Idle cycles in front of it drop valid, one assignment per falling edge.
    task automatic send_request(input t_req r);
        while ($urandom_range(99) < tx_idle_pct) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
        end
        @(negedge i_clk);
        req_ch.valid         <= 1'b1;
        req_ch.func          <= r.func;
        req_ch.requester_id  <= r.requester_id;
        req_ch.resource_mask <= r.resource_mask;
        @(posedge i_clk);
        while (!req_ch.ready)
            @(posedge i_clk);
    endtask

    // Mostly a handful of requesters fighting over a few resources at a time,
    // so grants, conflicts and early freeing all happen; some fully random noise.
    function automatic t_req random_req();
        t_req            r;
        int unsigned     pick;
        logic [MASK_W-1:0] mask;
        pick = $urandom_range(99);
        if (pick < 45)
            r.func = FUNC_ALLOC;
        else if (pick < 65)
            r.func = FUNC_RELEASE;
        else if (pick < 90)
            r.func = FUNC_CHECK;
        else
            r.func = 2'd3;      // unused kind, behaves as a check
        if ($urandom_range(99) < 75)
            r.requester_id = ID_W'($urandom_range(3));
        else
            r.requester_id = ID_W'($urandom_range(255));
        case ($urandom_range(9))
            0:       mask = MASK_W'($urandom_range(65535));
            1:       mask = '1;
            2:       mask = '0;
            3, 4, 5: mask = MASK_W'(1) << $urandom_range(MASK_W - 1);
            default: mask = (MASK_W'(16'hF) >> $urandom_range(2)) << $urandom_range(MASK_W - 1);
        endcase
        r.resource_mask = mask;
        return r;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            send_request(random_req());
    endtask

    initial begin : main
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.func          = '0;
        req_ch.requester_id  = '0;
        req_ch.resource_mask = '0;
        tx_idle_pct          = 0;
        rx_stall_pct         = 0;
        hold_request         = 1'b0;
        quiet_cycles         = 0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: extremes, every kind, the corner cases of the lock rules.
        // owner zero after reset: nothing busy, so id 0 sees everything free
        send_request(make_req(FUNC_CHECK,   8'd0,   16'hFFFF));
        // empty allocate still succeeds
        send_request(make_req(FUNC_ALLOC,   8'd0,   16'h0000));
        send_request(make_req(FUNC_ALLOC,   8'd255, 16'hFFFF));
        // conflict seen by check and by the unused kind
        send_request(make_req(FUNC_CHECK,   8'd0,   16'h8000));
        send_request(make_req(2'd3,         8'd1,   16'h0001));
        send_request(make_req(FUNC_CHECK,   8'd255, 16'hFFFF));
        send_request(make_req(FUNC_ALLOC,   8'd1,   16'h0001));
        // release works whoever owns the resource
        send_request(make_req(FUNC_RELEASE, 8'd1,   16'h00F0));
        // empty allocate frees all the requester owns
        send_request(make_req(FUNC_ALLOC,   8'd255, 16'h0000));
        send_request(make_req(FUNC_ALLOC,   8'd0,   16'h0003));
        // reallocating drops the previous set first
        send_request(make_req(FUNC_ALLOC,   8'd0,   16'h000C));
        send_request(make_req(FUNC_ALLOC,   8'd5,   16'h00F0));
        // failed allocate: id 0 loses 2..3 and still does not get 4..7
        send_request(make_req(FUNC_ALLOC,   8'd0,   16'h00F0));
        send_request(make_req(FUNC_CHECK,   8'd5,   16'h00F0));
        send_request(make_req(FUNC_ALLOC,   8'd7,   16'h00FF));
        send_request(make_req(FUNC_RELEASE, 8'd9,   16'hFFFF));
        send_request(make_req(FUNC_ALLOC,   8'd170, 16'hAAAA));
        send_request(make_req(FUNC_ALLOC,   8'd85,  16'h5555));
        send_request(make_req(FUNC_CHECK,   8'd85,  16'hFFFF));
        send_request(make_req(2'd3,         8'd170, 16'hAAAA));
        send_request(make_req(FUNC_RELEASE, 8'd0,   16'h0000));
        send_request(make_req(FUNC_RELEASE, 8'd255, 16'hFFFF));

        // Random phases: free running, slow sender, slow receiver, light on both.
        run_random(ITEMS_PER_PHASE);
        tx_idle_pct  = 57;
        run_random(ITEMS_PER_PHASE);
        tx_idle_pct  = 0;
        rx_stall_pct = 57;
        run_random(ITEMS_PER_PHASE);
        tx_idle_pct  = 7;
        rx_stall_pct = 7;
        run_random(ITEMS_PER_PHASE);

        // Back-pressure: receiver holds off while requests keep coming, so the
        // pipeline fills and the input stalls.
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_request = 1'b1;
        run_random(40);

        @(negedge i_clk);
        req_ch.valid <= 1'b0;

        // Drain; the watchdog catches results that never come.
        while (pending != 0)
            @(negedge i_clk);
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
design/mrlt_pkg.sv
design/mrlt_if.sv
design/mrlt_lock_core.sv
design/multi_resource_lock_table.sv
bench/lock_table_checker.sv
bench/testbench.sv
